// ===== rtl/sfhp_pkg.sv =====
package sfhp_pkg;

   localparam int DATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] WORD_BYTES = 32'd4;

   // result kinds
   localparam logic [1:0] KIND_SID = 2'd0;
   localparam logic [1:0] KIND_PAY = 2'd1;
   localparam logic [1:0] KIND_SUM = 2'd2;

   // frame status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   // flag codes
   localparam logic [3:0] FLAG_POS_SEQ = 4'd1;
   localparam logic [3:0] FLAG_NEG_SEQ = 4'd3;
   localparam logic [3:0] FLAG_EVENT   = 4'd4;

   // csr indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ERROR_MSG_TYPE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVT_START_CONN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVT_FINISH_CONN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EVT_CONN_STARTED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EVT_CONN_FAILED   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EVT_CONN_FINISHED = 3'd5;

   typedef struct packed {
      logic [3:0]        err_mtype;
      logic [DATA_W-1:0] evt_start_conn;
      logic [DATA_W-1:0] evt_finish_conn;
      logic [DATA_W-1:0] evt_conn_started;
      logic [DATA_W-1:0] evt_conn_failed;
      logic [DATA_W-1:0] evt_conn_finished;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic [7:0]               data_byte;
      logic [1:0]               status;
      logic [3:0]               hdr_mtype;
      logic [3:0]               flag_bits;
      logic [3:0]               serialization;
      logic [3:0]               compression;
      logic signed [DATA_W-1:0] sequence_res;
      logic [DATA_W-1:0]        err_value;
      logic signed [DATA_W-1:0] event_code;
      logic [DATA_W-1:0]        payload_length;
   } rsp_item_type;

   typedef struct packed {
      logic         byte_vld;
      logic         sum_vld;
      rsp_item_type byte_item;
      rsp_item_type sum_item;
   } par_out_type;

endpackage

// ===== rtl/sfhp_csr.sv =====
module sfhp_csr import sfhp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.err_mtype         <= 4'd15;
         cfg_ff.evt_start_conn    <= 32'd1;
         cfg_ff.evt_finish_conn   <= 32'd2;
         cfg_ff.evt_conn_started  <= 32'd50;
         cfg_ff.evt_conn_failed   <= 32'd51;
         cfg_ff.evt_conn_finished <= 32'd52;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ERROR_MSG_TYPE:    cfg_ff.err_mtype         <= csr_wdata[3:0];
            CSR_EVT_START_CONN:    cfg_ff.evt_start_conn    <= csr_wdata;
            CSR_EVT_FINISH_CONN:   cfg_ff.evt_finish_conn   <= csr_wdata;
            CSR_EVT_CONN_STARTED:  cfg_ff.evt_conn_started  <= csr_wdata;
            CSR_EVT_CONN_FAILED:   cfg_ff.evt_conn_failed   <= csr_wdata;
            CSR_EVT_CONN_FINISHED: cfg_ff.evt_conn_finished <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/sfhp_parser.sv =====
module sfhp_parser import sfhp_pkg::*; #(
   parameter int SID_CAP = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  logic [7:0]  frame_byte,
   input  logic        frame_end,
   input  cfg_type     cfg,
   output par_out_type result
);

   localparam int SW = $clog2(SID_CAP);
   localparam logic [SW-1:0] SidMax = SW'(SID_CAP - 1);

   typedef enum logic [3:0] {
      PH_H0, PH_HDR, PH_SEQ, PH_ERR, PH_EVT, PH_SIDLEN, PH_SID,
      PH_CIDLEN, PH_CID, PH_PLEN, PH_PAY, PH_DONE, PH_BAD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [DATA_W-1:0] fcnt_ff, fcnt_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [5:0]        hleft_ff, hleft_in;
   logic [3:0]        mtype_ff, mtype_in;
   logic [3:0]        flags_ff, flags_in;
   logic [7:0]        sercomp_ff, sercomp_in;
   logic [DATA_W-1:0] seq_ff, seq_in;
   logic [DATA_W-1:0] err_ff, err_in;
   logic [DATA_W-1:0] evt_ff, evt_in;
   logic [DATA_W-1:0] plen_ff, plen_in;
   logic [SW-1:0]     sidfwd_ff, sidfwd_in;
   logic [1:0]        status_ff, status_in;

   logic              word_phase, word_done;
   logic [DATA_W-1:0] acc_next, fcnt_inc, fcnt_dec, evt_cur;
   logic [5:0]        hleft_dec;
   logic              cid_evt, conn_evt;
   phase_type         tgt_after_err, tgt_after_seq, tgt_after_hdr;
   phase_type         tgt_after_sid, tgt_after_evt, begin_tgt;
   logic              begin_w, emit;
   logic [1:0]        emit_kind, sum_status;

   always_comb begin
      word_phase = phase_ff inside {PH_SEQ, PH_ERR, PH_EVT, PH_SIDLEN, PH_CIDLEN, PH_PLEN};
      acc_next   = {acc_ff[DATA_W-9:0], frame_byte};
      fcnt_inc   = fcnt_ff + 32'd1;
      fcnt_dec   = fcnt_ff - 32'd1;
      hleft_dec  = hleft_ff - 6'd1;
      word_done  = word_phase && (fcnt_inc >= WORD_BYTES);

      evt_cur  = (phase_ff == PH_EVT) ? acc_next : evt_ff;
      cid_evt  = (evt_cur == cfg.evt_conn_started) || (evt_cur == cfg.evt_conn_failed) ||
                 (evt_cur == cfg.evt_conn_finished);
      conn_evt = cid_evt || (evt_cur == cfg.evt_start_conn) ||
                 (evt_cur == cfg.evt_finish_conn);

      tgt_after_err = (flags_ff == FLAG_EVENT) ? PH_EVT : PH_PLEN;
      tgt_after_seq = (mtype_ff == cfg.err_mtype) ? PH_ERR : tgt_after_err;
      tgt_after_hdr = (flags_ff == FLAG_POS_SEQ || flags_ff == FLAG_NEG_SEQ) ?
                      PH_SEQ : tgt_after_seq;
      tgt_after_sid = cid_evt ? PH_CIDLEN : PH_PLEN;
      tgt_after_evt = conn_evt ? tgt_after_sid : PH_SIDLEN;
   end

   always_comb begin
      phase_in   = phase_ff;
      fcnt_in    = fcnt_ff;
      acc_in     = acc_ff;
      hleft_in   = hleft_ff;
      mtype_in   = mtype_ff;
      flags_in   = flags_ff;
      sercomp_in = sercomp_ff;
      seq_in     = seq_ff;
      err_in     = err_ff;
      evt_in     = evt_ff;
      plen_in    = plen_ff;
      sidfwd_in  = sidfwd_ff;
      status_in  = status_ff;
      begin_w    = 1'b0;
      begin_tgt  = PH_PLEN;
      emit       = 1'b0;
      emit_kind  = KIND_PAY;
      sum_status = ST_TRUNC;
      result     = '0;

      if (word_phase) begin
         fcnt_in = fcnt_inc;
         acc_in  = acc_next;
      end

      case (phase_ff)
         PH_H0: begin
            if (frame_byte[3:0] == 4'd0) begin
               status_in = ST_BAD;
               hleft_in  = 6'd3;
            end else begin
               hleft_in = {frame_byte[3:0], 2'b00} - 6'd1;
            end
            fcnt_in  = 32'd1;
            phase_in = PH_HDR;
         end
         PH_HDR: begin
            if (fcnt_ff == 32'd1) begin
               mtype_in = frame_byte[7:4];
               flags_in = frame_byte[3:0];
            end else if (fcnt_ff == 32'd2) begin
               sercomp_in = frame_byte;
            end
            fcnt_in  = fcnt_inc;
            hleft_in = hleft_dec;
            if (hleft_dec == 6'd0) begin
               if (status_ff == ST_BAD) begin
                  phase_in = PH_BAD;
               end else begin
                  begin_w   = 1'b1;
                  begin_tgt = tgt_after_hdr;
               end
            end
         end
         PH_SEQ: begin
            if (word_done) begin
               seq_in    = acc_next;
               begin_w   = 1'b1;
               begin_tgt = tgt_after_seq;
            end
         end
         PH_ERR: begin
            if (word_done) begin
               err_in    = acc_next;
               begin_w   = 1'b1;
               begin_tgt = tgt_after_err;
            end
         end
         PH_EVT: begin
            if (word_done) begin
               evt_in    = acc_next;
               begin_w   = 1'b1;
               begin_tgt = tgt_after_evt;
            end
         end
         PH_SIDLEN: begin
            if (word_done) begin
               if (acc_next == '0) begin
                  begin_w   = 1'b1;
                  begin_tgt = tgt_after_sid;
               end else begin
                  fcnt_in  = acc_next;
                  phase_in = PH_SID;
               end
            end
         end
         PH_SID: begin
            if (sidfwd_ff < SidMax) begin
               emit      = 1'b1;
               emit_kind = KIND_SID;
               sidfwd_in = sidfwd_ff + SW'(1);
            end
            fcnt_in = fcnt_dec;
            if (fcnt_dec == '0) begin
               begin_w   = 1'b1;
               begin_tgt = tgt_after_sid;
            end
         end
         PH_CIDLEN: begin
            if (word_done) begin
               if (acc_next == '0) begin
                  begin_w   = 1'b1;
                  begin_tgt = PH_PLEN;
               end else begin
                  fcnt_in  = acc_next;
                  phase_in = PH_CID;
               end
            end
         end
         PH_CID: begin
            fcnt_in = fcnt_dec;
            if (fcnt_dec == '0) begin
               begin_w   = 1'b1;
               begin_tgt = PH_PLEN;
            end
         end
         PH_PLEN: begin
            if (word_done) begin
               plen_in = acc_next;
               if (acc_next == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  fcnt_in  = acc_next;
                  phase_in = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            emit      = 1'b1;
            emit_kind = KIND_PAY;
            fcnt_in   = fcnt_dec;
            if (fcnt_dec == '0) begin
               phase_in = PH_DONE;
            end
         end
         default: ;
      endcase

      if (begin_w) begin
         phase_in = begin_tgt;
         fcnt_in  = '0;
         acc_in   = '0;
      end

      if (phase_in == PH_DONE) begin
         sum_status = ST_OK;
      end else if (phase_in == PH_BAD) begin
         sum_status = ST_BAD;
      end

      result.byte_vld            = req_fire && emit;
      result.byte_item.kind      = emit_kind;
      result.byte_item.data_byte = frame_byte;

      result.sum_vld                     = req_fire && frame_end;
      result.sum_item.kind               = KIND_SUM;
      result.sum_item.status             = sum_status;
      result.sum_item.hdr_mtype          = mtype_in;
      result.sum_item.flag_bits          = flags_in;
      result.sum_item.serialization      = sercomp_in[7:4];
      result.sum_item.compression        = sercomp_in[3:0];
      result.sum_item.sequence_res       = seq_in;
      result.sum_item.err_value          = err_in;
      result.sum_item.event_code         = evt_in;
      result.sum_item.payload_length     = plen_in;

      // end of frame: drop all per-frame state
      if (frame_end) begin
         phase_in   = PH_H0;
         fcnt_in    = '0;
         acc_in     = '0;
         hleft_in   = '0;
         mtype_in   = '0;
         flags_in   = '0;
         sercomp_in = '0;
         seq_in     = '0;
         err_in     = '0;
         evt_in     = '0;
         plen_in    = '0;
         sidfwd_in  = '0;
         status_in  = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_H0;
         fcnt_ff    <= '0;
         acc_ff     <= '0;
         hleft_ff   <= '0;
         mtype_ff   <= '0;
         flags_ff   <= '0;
         sercomp_ff <= '0;
         seq_ff     <= '0;
         err_ff     <= '0;
         evt_ff     <= '0;
         plen_ff    <= '0;
         sidfwd_ff  <= '0;
         status_ff  <= ST_OK;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         acc_ff     <= acc_in;
         hleft_ff   <= hleft_in;
         mtype_ff   <= mtype_in;
         flags_ff   <= flags_in;
         sercomp_ff <= sercomp_in;
         seq_ff     <= seq_in;
         err_ff     <= err_in;
         evt_ff     <= evt_in;
         plen_ff    <= plen_in;
         sidfwd_ff  <= sidfwd_in;
         status_ff  <= status_in;
      end
   end

endmodule

// ===== rtl/sfhp_rsp_queue.sv =====
module sfhp_rsp_queue import sfhp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  par_out_type  push,
   input  logic         pop,
   output rsp_item_type head,
   output logic         not_empty,
   output logic         room
);

   rsp_item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    first_vld, both_vld;
   rsp_item_type            first_item;
   logic [QCNT_W-1:0]       push_n;
   logic [QPTR_W-1:0]       wptr_next;

   always_comb begin
      first_vld  = push.byte_vld || push.sum_vld;
      both_vld   = push.byte_vld && push.sum_vld;
      first_item = push.byte_vld ? push.byte_item : push.sum_item;
      push_n     = both_vld ? QCNT_W'(2) : (first_vld ? QCNT_W'(1) : '0);
      wptr_next  = wptr_ff + QPTR_W'(1);
      wptr_in    = wptr_ff + QPTR_W'(push_n);
      rptr_in    = pop ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in   = count_ff + push_n - QCNT_W'(pop);
   end

   assign head      = entry_ff[rptr_ff];
   assign not_empty = (count_ff != '0);
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (first_vld) begin
         entry_ff[wptr_ff] <= first_item;
      end
      if (both_vld) begin
         entry_ff[wptr_next] <= push.sum_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/speech_frame_header_parser.sv =====
// Speech frame header parser.
// Request channel (req_valid/req_ready): one frame byte per request,
// req_frame_end set on the last byte of a frame.
// Response channel (rsp_valid/rsp_ready): session id bytes (kind 0),
// payload bytes (kind 1) and one frame summary (kind 2) per frame, in order.
// CSR channel (csr_valid/csr_ready): register index and write data; always
// ready. CSRs are to be written only while no request is in flight; the
// user must ensure this, as the block itself does not enforce it.
// Responses of a request enter the queue in the cycle after it is taken.
// Throughput: one request per cycle while req_ready is high; a request
// yields at most two responses (a byte plus a summary), which wait in a
// 4-entry queue; req_ready drops when fewer than two entries are free, so
// a stalled receiver backs up into the request side and nothing is lost.
// Reset: parser returns to the first header byte, the queue empties and the
// CSRs return to their default codes.
module speech_frame_header_parser import sfhp_pkg::*; #(
   parameter int SID_CAP = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_frame_byte,
   input  logic                     req_frame_end,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [7:0]               rsp_data_byte,
   output logic [1:0]               rsp_status,
   output logic [3:0]               rsp_hdr_mtype,
   output logic [3:0]               rsp_flag_bits,
   output logic [3:0]               rsp_serialization,
   output logic [3:0]               rsp_compression,
   output logic signed [DATA_W-1:0] rsp_sequence_res,
   output logic [DATA_W-1:0]        rsp_err_value,
   output logic signed [DATA_W-1:0] rsp_event_code,
   output logic [DATA_W-1:0]        rsp_payload_length,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   cfg_type      cfg;
   par_out_type  par_out;
   rsp_item_type head;
   logic         req_fire;
   logic         room;

   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;

   sfhp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sfhp_parser #(
      .SID_CAP (SID_CAP)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .frame_byte (req_frame_byte),
      .frame_end  (req_frame_end),
      .cfg        (cfg),
      .result     (par_out)
   );

   sfhp_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (par_out),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room      (room)
   );

   assign rsp_kind           = head.kind;
   assign rsp_data_byte      = head.data_byte;
   assign rsp_status         = head.status;
   assign rsp_hdr_mtype      = head.hdr_mtype;
   assign rsp_flag_bits      = head.flag_bits;
   assign rsp_serialization  = head.serialization;
   assign rsp_compression    = head.compression;
   assign rsp_sequence_res   = head.sequence_res;
   assign rsp_err_value      = head.err_value;
   assign rsp_event_code     = head.event_code;
   assign rsp_payload_length = head.payload_length;

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with empty response queue");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> rsp_valid)
      else $error("frame end request produced no response");

   a_sum_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_SUM |-> rsp_data_byte == 8'd0)
      else $error("summary carries a data byte");

   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SUM |-> rsp_status == ST_OK && rsp_payload_length == '0)
      else $error("byte response carries summary fields");

endmodule
